@@ sv/log_sample_to_linear_pcm_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the log sample expander
// Same-cycle and next-cycle implication checks, cleared while in reset.
// ----------------------------------------------------------------------------
`ifndef LOG_SAMPLE_TO_LINEAR_PCM_TOP_ASSERT_SVH
`define LOG_SAMPLE_TO_LINEAR_PCM_TOP_ASSERT_SVH

// condition holds in the same cycle
`define LSPCM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lspcm: same-cycle check failed");

// condition holds in the next cycle
`define LSPCM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lspcm: next-cycle check failed");

`endif

@@ sv/lspcm_pkg.sv @@
// ----------------------------------------------------------------------------
// lspcm_pkg
// Widths, stage enables and the exp2 fraction table of the sample expander.
// ----------------------------------------------------------------------------
`default_nettype none

package lspcm_pkg;

    localparam int TABLE_FRACTION_BITS = 24;
    localparam int WORD_W              = 16;
    localparam int EXP_ADDR_W          = 11;
    localparam int EXP_ENTRIES         = 1 << EXP_ADDR_W;
    localparam int IDX_W               = WORD_W - EXP_ADDR_W;
    localparam int ENTRY_W             = TABLE_FRACTION_BITS + 1;
    localparam int SHIFT_W             = $clog2(TABLE_FRACTION_BITS + 2);
    localparam int MAG_W               = 16;
    localparam int NUM_STAGES          = 4;

    typedef logic [ENTRY_W-1:0] exp_entry_t;
    typedef exp_entry_t exp_table_t [EXP_ENTRIES];

    // enables of the two back stages
    typedef struct packed {
        logic shift;
        logic out;
    } back_en_t;

    // (a * b) >> 62, truncating, Q2.62
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // floor square root in Q2.62
    function automatic logic [63:0] sqrt_q62(input logic [63:0] x);
        logic [63:0] y;
        logic [63:0] c;
        y = '0;
        for (int b = 62; b >= 0; b--) begin
            c = y | (64'd1 << b);
            if (mul_q62(c, c) <= x)
                y = c;
        end
        return y;
    endfunction

    // T[f] = round(2^(f/2048) * 2^TABLE_FRACTION_BITS), worked out at elaboration
    function automatic exp_table_t build_exp_table();
        exp_table_t  tab;
        logic [63:0] root [EXP_ADDR_W];
        logic [63:0] one;
        logic [63:0] v;
        logic [63:0] p;
        logic [63:0] rnd;
        one = 64'd1 << 62;
        v   = sqrt_q62(one + (one - 64'd1));
        // nudge up to the floor root of exactly 2.0
        for (int n = 0; n < 4; n++) begin
            if (mul_q62(v + 64'd1, v + 64'd1) < (one << 1) && (v + 64'd1) < (64'd1 << 63))
                v = v + 64'd1;
        end
        root[EXP_ADDR_W-1] = v;
        for (int k = EXP_ADDR_W - 2; k >= 0; k--)
            root[k] = sqrt_q62(root[k+1]);
        for (int f = 0; f < EXP_ENTRIES; f++) begin
            p = one;
            for (int b = 0; b < EXP_ADDR_W; b++) begin
                if (((f >> b) & 1) != 0)
                    p = mul_q62(p, root[b]);
            end
            rnd    = (p + (64'd1 << (62 - TABLE_FRACTION_BITS - 1))) >> (62 - TABLE_FRACTION_BITS);
            tab[f] = rnd[ENTRY_W-1:0];
        end
        return tab;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

`default_nettype wire

@@ sv/lspcm_decode.sv @@
// ----------------------------------------------------------------------------
// lspcm_decode
// Bit reorder of the stored word; splits m+1 into octave and table index.
// ----------------------------------------------------------------------------
`default_nettype none

module lspcm_decode import lspcm_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic [WORD_W-1:0]     word,
    output logic                       sign_reg,
    output logic [IDX_W-1:0]           octave_reg,
    output logic [EXP_ADDR_W-1:0]      frac_reg
);

    logic [WORD_W-2:0] mant;
    logic [WORD_W-1:0] t_next;

    // log magnitude: stored 6, 14..8, 5..0, 7 from the top down
    assign mant   = {word[6], word[14:8], word[5:0], word[7]};
    assign t_next = {1'b0, mant} + WORD_W'(1);

    always_ff @(posedge aclk) begin
        if (en) begin
            sign_reg   <= word[15];
            octave_reg <= t_next[WORD_W-1:EXP_ADDR_W];
            frac_reg   <= t_next[EXP_ADDR_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ sv/lspcm_exp.sv @@
// ----------------------------------------------------------------------------
// lspcm_exp
// Fraction table read and right-shift amount.
// ----------------------------------------------------------------------------
`default_nettype none

module lspcm_exp import lspcm_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic                  sign,
    input  wire logic [IDX_W-1:0]      octave,
    input  wire logic [EXP_ADDR_W-1:0] frac,
    output logic                       sign_reg,
    output exp_entry_t                 entry_reg,
    output logic [SHIFT_W-1:0]         shift_reg
);

    always_ff @(posedge aclk) begin
        if (en) begin
            sign_reg  <= sign;
            entry_reg <= EXP_TABLE[frac];
            shift_reg <= SHIFT_W'(TABLE_FRACTION_BITS + 1) - SHIFT_W'(octave);
        end
    end

endmodule

`default_nettype wire

@@ sv/lspcm_shift.sv @@
// ----------------------------------------------------------------------------
// lspcm_shift
// Shift to linear magnitude, then sign, with the top positive code saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module lspcm_shift import lspcm_pkg::*; (
    input  wire logic                  aclk,
    input  back_en_t                   en,
    input  wire logic                  sign,
    input  exp_entry_t                 entry,
    input  wire logic [SHIFT_W-1:0]    shift,
    output logic signed [WORD_W-1:0]   pcm_reg
);

    exp_entry_t                 shifted;
    logic                       sign_mag_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic signed [WORD_W-1:0]   pcm_next;

    assign shifted = entry >> shift;

    always_comb begin
        if (sign_mag_reg)
            pcm_next = WORD_W'(-mag_reg);
        else if (mag_reg[MAG_W-1])
            pcm_next = 16'sh7fff;   // 32768 does not fit
        else
            pcm_next = WORD_W'(mag_reg);
    end

    always_ff @(posedge aclk) begin
        if (en.shift) begin
            sign_mag_reg <= sign;
            mag_reg      <= shifted[MAG_W-1:0];
        end
        if (en.out)
            pcm_reg <= pcm_next;
    end

endmodule

`default_nettype wire

@@ sv/log_sample_to_linear_pcm_top.sv @@
// ----------------------------------------------------------------------------
// log_sample_to_linear_pcm_top
// Expands scrambled log-coded 16-bit sample words into linear PCM samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one stored sample word per item (first byte high byte).
//   m_ channel returns one signed 16-bit PCM sample per item, in order.
//   Four register stages (decode, table read, shift, sign/saturate) lead
//   from the accepting edge to m_tvalid, each with its own valid bit, the
//   first loaded at the accepting edge.
//   Throughput is one item per cycle while m_tready is high; the table read
//   is a constant ROM addressed once per item, so no stage is shared.
//   When m_tready is low the output item holds; upstream stages keep filling
//   empty slots, and s_tready drops only once every stage holds an item.
//   Reset (aresetn low, synchronous) empties all stages; no item is lost or
//   repeated across a stall. The table is a constant and needs no fill pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "log_sample_to_linear_pcm_top_assert.svh"

module log_sample_to_linear_pcm_top import lspcm_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [WORD_W-1:0]     s_tdata,   // [15:0] stored_word
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic signed [WORD_W-1:0]   m_tdata    // [15:0] pcm_sample
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] en;

    logic                  sign_a;
    logic [IDX_W-1:0]      octave_a;
    logic [EXP_ADDR_W-1:0] frac_a;
    logic                  sign_b;
    exp_entry_t            entry_b;
    logic [SHIFT_W-1:0]    shift_b;
    back_en_t              back_en;

    // a stage loads when empty or when its item moves on
    always_comb begin
        en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
        valid_next = valid_reg;
        if (en[0])
            valid_next[0] = s_tvalid;
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (en[k])
                valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready      = en[0];
    assign m_tvalid      = valid_reg[NUM_STAGES-1];
    assign back_en.shift = en[2];
    assign back_en.out   = en[3];

    lspcm_decode u_decode (
        .aclk       (aclk),
        .en         (en[0]),
        .word       (s_tdata),
        .sign_reg   (sign_a),
        .octave_reg (octave_a),
        .frac_reg   (frac_a)
    );

    lspcm_exp u_exp (
        .aclk      (aclk),
        .en        (en[1]),
        .sign      (sign_a),
        .octave    (octave_a),
        .frac      (frac_a),
        .sign_reg  (sign_b),
        .entry_reg (entry_b),
        .shift_reg (shift_b)
    );

    lspcm_shift u_shift (
        .aclk    (aclk),
        .en      (back_en),
        .sign    (sign_b),
        .entry   (entry_b),
        .shift   (shift_b),
        .pcm_reg (m_tdata)
    );

    `LSPCM_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready, valid_reg[0])
    `LSPCM_ASSERT_NOW(a_stall_only_full, aclk, aresetn, !s_tready, valid_reg == '1)
    `LSPCM_ASSERT_NEXT(a_no_drop, aclk, aresetn, valid_reg[2] && en[2], valid_reg[3])
    `LSPCM_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, valid_reg[1] && !en[1], valid_reg[1])

endmodule

`default_nettype wire
